FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDDA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gdda: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GDDA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("gdda: next-cycle check failed");

`endif

FILE: rtl/gdda_pkg.sv
// Package with the types, constants and calendar functions of the date arithmetic block.
`default_nettype none

package gdda_pkg;

  localparam int YP_W = 17;
  localparam int U_W  = 25;
  localparam int T_W  = 27;

  // Years are biased by a multiple of 400 so that every legal year is positive.
  localparam int YEAR_BIAS = 33200;
  localparam logic [YP_W-1:0] YP_BIAS = YP_W'(YEAR_BIAS);

  function automatic int start_c(input int yp);
    return 365 * yp + (yp + 3) / 4 - (yp + 99) / 100 + (yp + 399) / 400;
  endfunction

  // Day numbers of 1 January of the lowest legal year and of the year after the highest.
  localparam logic signed [T_W-1:0] T_LO = T_W'(start_c(YEAR_BIAS - 32768));
  localparam logic signed [T_W-1:0] T_HI = T_W'(start_c(YEAR_BIAS + 32768));

  // Reciprocal of the mean year length, scaled by two to the 32nd.
  localparam logic [23:0] EST_K = 24'((64'd400 << 32) / 64'd146097);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SA1, S_SA2, S_SB1, S_SB2, S_TSUM, S_EST,
    S_Y1, S_Y2, S_N1, S_N2, S_MON, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CHECK, CMD_SU_A, CMD_SU_B, CMD_SU_Y, CMD_SU_Y1,
    CMD_CAP_A, CMD_CAP_B, CMD_TSUM, CMD_EST, CMD_YDEC, CMD_SKEEP, CMD_YINC,
    CMD_MONTH, CMD_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic bad;
    logic out_rng;
    logic s_gt_t;
  } dp_sts_t;

  // Floor of n / 25, exact for n below 43690.
  function automatic logic [10:0] div25(input logic [14:0] n);
    logic [27:0] p;
    p = 28'(n) * 28'd5243;
    return p[27:17];
  endfunction

  function automatic logic leap_f(input logic [YP_W-1:0] yp);
    logic [14:0] q4;
    logic [12:0] q16;
    logic [10:0] d4;
    logic [10:0] d16;
    logic        c100;
    logic        c400;
    q4   = yp[16:2];
    q16  = yp[16:4];
    d4   = div25(q4);
    d16  = div25({2'b00, q16});
    c100 = ((15'(d4) * 15'd25) == q4);
    c400 = (yp[3:0] == 4'd0) && ((15'(d16) * 15'd25) == {2'b00, q16});
    return (yp[1:0] == 2'd0) && (!c100 || c400);
  endfunction

  // Days in the months before month m.
  function automatic logic [8:0] cum_f(input logic leap, input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m >= 4'd3) && (m <= 4'd12)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  function automatic logic [4:0] mlen_f(input logic leap, input logic [3:0] m);
    logic [4:0] l;
    case (m)
      4'd2:    l = leap ? 5'd29 : 5'd28;
      4'd4:    l = 5'd30;
      4'd6:    l = 5'd30;
      4'd9:    l = 5'd30;
      4'd11:   l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

  function automatic logic date_ok(input logic leap, input logic [3:0] m,
                                   input logic [4:0] d);
    return (m >= 4'd1) && (m <= 4'd12) && (d != 5'd0) && (d <= mlen_f(leap, m));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gdda_ctrl.sv
// Controller state machine that sequences the date arithmetic datapath.
`default_nettype none

module gdda_ctrl
  import gdda_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = sts.bad ? S_OUT : S_SA1;
      S_SA1:   state_nxt = S_SA2;
      S_SA2:   state_nxt = sts.op ? S_SB1 : S_TSUM;
      S_SB1:   state_nxt = S_SB2;
      S_SB2:   state_nxt = S_OUT;
      S_TSUM:  state_nxt = sts.out_rng ? S_OUT : S_EST;
      S_EST:   state_nxt = S_Y1;
      S_Y1:    state_nxt = S_Y2;
      S_Y2:    state_nxt = sts.s_gt_t ? S_Y1 : S_N1;
      S_N1:    state_nxt = S_N2;
      S_N2:    state_nxt = sts.s_gt_t ? S_MON : S_N1;
      S_MON:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = CMD_NONE;
    in_stall      = (state_r != S_IDLE);
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE:  if (in_valid) cmd = CMD_LOAD;
      S_CHECK: cmd = CMD_CHECK;
      S_SA1:   cmd = CMD_SU_A;
      S_SA2:   cmd = CMD_CAP_A;
      S_SB1:   cmd = CMD_SU_B;
      S_SB2:   cmd = CMD_CAP_B;
      S_TSUM:  cmd = CMD_TSUM;
      S_EST:   cmd = CMD_EST;
      S_Y1:    cmd = CMD_SU_Y;
      S_Y2:    cmd = sts.s_gt_t ? CMD_YDEC : CMD_SKEEP;
      S_N1:    cmd = CMD_SU_Y1;
      S_N2:    cmd = sts.s_gt_t ? CMD_NONE : CMD_YINC;
      S_MON:   cmd = CMD_MONTH;
      S_OUT: begin
        if (out_free) begin
          cmd           = CMD_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/gdda_dp.sv
// Datapath with the year-start unit, day numbers, year search and result registers.
`default_nettype none

module gdda_dp
  import gdda_pkg::*;
(
  input  logic                clk,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic                in_op,
  input  logic signed [15:0]  in_year_a,
  input  logic [3:0]          in_month_a,
  input  logic [4:0]          in_day_a,
  input  logic signed [25:0]  in_day_offset,
  input  logic signed [15:0]  in_year_b,
  input  logic [3:0]          in_month_b,
  input  logic [4:0]          in_day_b,
  output logic signed [15:0]  out_year_out,
  output logic [3:0]          out_month_out,
  output logic [4:0]          out_day_out,
  output logic signed [25:0]  out_day_count,
  output logic [1:0]          out_status
);

  logic                   op_r;
  logic [YP_W-1:0]        ypa_r;
  logic [3:0]             ma_r;
  logic [4:0]             da_r;
  logic signed [25:0]     off_r;
  logic [YP_W-1:0]        ypb_r;
  logic [3:0]             mb_r;
  logic [4:0]             db_r;
  logic [1:0]             st_r;
  logic [YP_W-1:0]        su_yp_r;
  logic [14:0]            su_a_r;
  logic [10:0]            su_b_r;
  logic [10:0]            su_c_r;
  logic                   su_leap_r;
  logic [U_W-1:0]         u_a_r;
  logic [U_W-1:0]         u_b_r;
  logic signed [T_W-1:0]  t_r;
  logic [YP_W-1:0]        y_r;
  logic [U_W-1:0]         s_r;
  logic                   s_leap_r;
  logic signed [15:0]     res_year_r;
  logic [3:0]             res_month_r;
  logic [4:0]             res_day_r;
  logic signed [15:0]     out_year_r;
  logic [3:0]             out_month_r;
  logic [4:0]             out_day_r;
  logic signed [25:0]     out_count_r;
  logic [1:0]             out_status_r;

  logic [YP_W-1:0]        su_sel;
  logic [17:0]            sel_p3;
  logic [17:0]            sel_p99;
  logic [17:0]            sel_p399;
  logic [25:0]            start_full;
  logic [U_W-1:0]         start_w;
  logic [3:0]             cap_m;
  logic [4:0]             cap_d;
  logic [U_W-1:0]         serial_w;
  logic signed [T_W-1:0]  t_sum;
  logic                   rng_ok;
  logic [48:0]            est_prod;
  logic [8:0]             doy;
  logic [3:0]             mon;
  logic [8:0]             day_full;
  logic [YP_W-1:0]        year_full;
  logic                   bad;

  assign bad = !date_ok(leap_f(ypa_r), ma_r, da_r) ||
               (op_r && !date_ok(leap_f(ypb_r), mb_r, db_r));

  always_comb begin
    case (cmd)
      CMD_SU_B:  su_sel = ypb_r;
      CMD_SU_Y:  su_sel = y_r;
      CMD_SU_Y1: su_sel = y_r + YP_W'(1);
      default:   su_sel = ypa_r;
    endcase
  end

  assign sel_p3   = 18'(su_sel) + 18'd3;
  assign sel_p99  = 18'(su_sel) + 18'd99;
  assign sel_p399 = 18'(su_sel) + 18'd399;

  // Day number of 1 January of the biased year held in the first stage.
  assign start_full = 26'(su_yp_r) * 26'd365 + 26'(su_a_r) - 26'(su_b_r) + 26'(su_c_r);
  assign start_w    = start_full[U_W-1:0];

  assign cap_m    = (cmd == CMD_CAP_B) ? mb_r : ma_r;
  assign cap_d    = (cmd == CMD_CAP_B) ? db_r : da_r;
  assign serial_w = start_w + U_W'(cum_f(su_leap_r, cap_m)) + U_W'(cap_d) - U_W'(1);

  assign t_sum  = $signed({2'b00, u_a_r}) + T_W'(off_r);
  assign rng_ok = (t_sum >= T_LO) && (t_sum < T_HI);

  assign est_prod = 49'(t_r[U_W-1:0]) * 49'(EST_K);

  assign doy = 9'(t_r[U_W-1:0] - s_r);

  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy >= cum_f(s_leap_r, 4'(k))) begin
        mon = 4'(k);
      end
    end
  end

  assign day_full  = doy - cum_f(s_leap_r, mon) + 9'd1;
  assign year_full = y_r - YP_BIAS;

  assign sts.op      = op_r;
  assign sts.bad     = bad;
  assign sts.out_rng = !rng_ok;
  assign sts.s_gt_t  = (start_w > t_r[U_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd == CMD_SU_A || cmd == CMD_SU_B || cmd == CMD_SU_Y || cmd == CMD_SU_Y1) begin
      su_yp_r   <= su_sel;
      su_a_r    <= sel_p3[16:2];
      su_b_r    <= div25(sel_p99[16:2]);
      su_c_r    <= div25({2'b00, sel_p399[16:4]});
      su_leap_r <= leap_f(su_sel);
    end
    case (cmd)
      CMD_LOAD: begin
        op_r  <= in_op;
        ypa_r <= YP_W'({in_year_a[15], in_year_a}) + YP_BIAS;
        ma_r  <= in_month_a;
        da_r  <= in_day_a;
        off_r <= in_day_offset;
        ypb_r <= YP_W'({in_year_b[15], in_year_b}) + YP_BIAS;
        mb_r  <= in_month_b;
        db_r  <= in_day_b;
      end
      CMD_CHECK: st_r  <= bad ? ST_BAD : ST_OK;
      CMD_CAP_A: u_a_r <= serial_w;
      CMD_CAP_B: u_b_r <= serial_w;
      CMD_TSUM: begin
        t_r <= t_sum;
        if (!rng_ok) begin
          st_r <= ST_RANGE;
        end
      end
      CMD_EST:  y_r <= est_prod[48:32];
      CMD_YDEC: y_r <= y_r - YP_W'(1);
      CMD_SKEEP: begin
        s_r      <= start_w;
        s_leap_r <= su_leap_r;
      end
      CMD_YINC: begin
        y_r      <= y_r + YP_W'(1);
        s_r      <= start_w;
        s_leap_r <= su_leap_r;
      end
      CMD_MONTH: begin
        res_year_r  <= $signed(year_full[15:0]);
        res_month_r <= mon;
        res_day_r   <= day_full[4:0];
      end
      CMD_OUT: begin
        out_status_r <= st_r;
        out_year_r   <= '0;
        out_month_r  <= '0;
        out_day_r    <= '0;
        out_count_r  <= '0;
        if (st_r == ST_OK) begin
          if (op_r) begin
            out_count_r <= $signed({1'b0, u_a_r} - {1'b0, u_b_r});
          end else begin
            out_year_r  <= res_year_r;
            out_month_r <= res_month_r;
            out_day_r   <= res_day_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_year_out  = out_year_r;
  assign out_month_out = out_month_r;
  assign out_day_out   = out_day_r;
  assign out_day_count = out_count_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

FILE: rtl/gregorian_date_day_arithmetic_core.sv
// Top level of the proleptic Gregorian date arithmetic block.
//
// Use: a transaction on the input channel (in_valid high, in_stall low at a
// rising edge) carries one request. With in_op low the block adds the signed
// in_day_offset to date A; with in_op high it returns the days from date B to
// date A. Each request produces exactly one result transaction on the output
// channel, taken when out_valid is high and out_stall is low.
// Steps: a day difference checks the dates and converts date A, then date B, in
// the year-start unit. A date addition converts date A, adds the offset, estimates
// the year, corrects it down and then up, and finds the month. Invalid dates go
// straight from the check to the output, out-of-range sums from the offset sum.
// Throughput: one request at a time; in_stall is high from the cycle after
// acceptance until the result has been written into the output register. The
// year search shares the single year-start unit with the date conversions.
// A result may wait in the output register while the next request is taken;
// while the receiver stalls, the result holds steady and a finished request
// waits in its final state.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; no result in flight survives it.
`default_nettype none

module gregorian_date_day_arithmetic_core
  import gdda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [15:0] in_year_a,
  input  logic [3:0]         in_month_a,
  input  logic [4:0]         in_day_a,
  input  logic signed [25:0] in_day_offset,
  input  logic signed [15:0] in_year_b,
  input  logic [3:0]         in_month_b,
  input  logic [4:0]         in_day_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_year_out,
  output logic [3:0]         out_month_out,
  output logic [4:0]         out_day_out,
  output logic signed [25:0] out_day_count,
  output logic [1:0]         out_status
);

  // Commands flow from the controller to the datapath, flags flow back.
  dp_cmd_t cmd;
  dp_sts_t sts;

  gdda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdda_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_year_a     (in_year_a),
    .in_month_a    (in_month_a),
    .in_day_a      (in_day_a),
    .in_day_offset (in_day_offset),
    .in_year_b     (in_year_b),
    .in_month_b    (in_month_b),
    .in_day_b      (in_day_b),
    .out_year_out  (out_year_out),
    .out_month_out (out_month_out),
    .out_day_out   (out_day_out),
    .out_day_count (out_day_count),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

FILE: rtl/gdda_checker.sv
// Port-level checker for the date arithmetic block and its bind statement.
`default_nettype none

`include "assert_macros.svh"

module gdda_checker
  import gdda_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_year_out,
  input logic [3:0]         out_month_out,
  input logic [4:0]         out_day_out,
  input logic signed [25:0] out_day_count,
  input logic [1:0]         out_status
);

  // A stalled result stays offered.
  `GDDA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // Only one request is worked on at a time.
  `GDDA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // Failed requests carry all-zero payload fields.
  `GDDA_ASSERT_IMP(a_fail_zero, clk, rst_n,
    out_valid && (out_status == ST_BAD || out_status == ST_RANGE),
    out_year_out == 16'sd0 && out_month_out == 4'd0 && out_day_out == 5'd0 &&
    out_day_count == 26'sd0)

  // A returned date is a calendar date and leaves the day count clear.
  `GDDA_ASSERT_IMP(a_date_shape, clk, rst_n,
    out_valid && out_status == ST_OK && out_month_out != 4'd0,
    out_month_out <= 4'd12 && out_day_out != 5'd0 && out_day_count == 26'sd0)

  // The status code never takes its unused value.
  `GDDA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
    out_status == ST_OK || out_status == ST_BAD || out_status == ST_RANGE)

endmodule

bind gregorian_date_day_arithmetic_core gdda_checker u_gdda_checker (.*);

`default_nettype wire

FILE: bench/tb_gregorian_date_day_arithmetic_core.sv
// Self-checking testbench for the Gregorian date arithmetic core.
`default_nettype none

module tb_gregorian_date_day_arithmetic_core;
  import gdda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_DIFF = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [15:0] year_a;
    logic [3:0]         month_a;
    logic [4:0]         day_a;
    logic signed [25:0] day_offset;
    logic signed [15:0] year_b;
    logic [3:0]         month_b;
    logic [4:0]         day_b;
  } date_req_t;

  typedef struct packed {
    logic signed [15:0] year_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic signed [25:0] day_count;
    logic [1:0]         status;
  } date_res_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_op;
  logic signed [15:0] in_year_a;
  logic [3:0]         in_month_a;
  logic [4:0]         in_day_a;
  logic signed [25:0] in_day_offset;
  logic signed [15:0] in_year_b;
  logic [3:0]         in_month_b;
  logic [4:0]         in_day_b;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_year_out;
  logic [3:0]         out_month_out;
  logic [4:0]         out_day_out;
  logic signed [25:0] out_day_count;
  logic [1:0]         out_status;

  // Predicted results, oldest at the front of the queue.
  date_res_t pending_dates[$];
  int        fail_count;
  bit        rx_stall_bursts;

  gregorian_date_day_arithmetic_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_year_a(in_year_a), .in_month_a(in_month_a), .in_day_a(in_day_a),
    .in_day_offset(in_day_offset), .in_year_b(in_year_b),
    .in_month_b(in_month_b), .in_day_b(in_day_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_year_out(out_year_out), .out_month_out(out_month_out),
    .out_day_out(out_day_out), .out_day_count(out_day_count),
    .out_status(out_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Calendar arithmetic, carried out in 64-bit signed integers.
  // ---------------------------------------------------------------------

  // Division rounding towards minus infinity.
  function automatic longint floor_div(longint n, longint d);
    return (n >= 0) ? n / d : -1 - ((-1 - n) / d);
  endfunction

  // Leap years by the 4/100/400 rule, applied to negative years as well.
  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint y, int m);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic longint days_before_month(longint y, int m);
    longint acc;
    acc = 0;
    for (int k = 1; k < m; k++) acc += month_days(y, k);
    return acc;
  endfunction

  function automatic bit valid_date(longint y, int m, int d);
    if (m < 1 || m > 12 || d < 1) return 1'b0;
    return d <= month_days(y, m);
  endfunction

  // Days from 1 January of year 0 to 1 January of year y.
  function automatic longint jan_first(longint y);
    longint p;
    p = y - 1;
    return 365 * y + floor_div(p, 4) - floor_div(p, 100) + floor_div(p, 400) + 1;
  endfunction

  function automatic longint serial_day(longint y, int m, int d);
    return jan_first(y) + days_before_month(y, m) + d - 1;
  endfunction

  // Works out the result that the core must give for one request.
  function automatic date_res_t predict_date(date_req_t r);
    date_res_t res;
    longint    t, y, doy;
    int        m;
    res = '0;
    if (!valid_date(r.year_a, r.month_a, r.day_a) ||
        (r.op == OP_DIFF && !valid_date(r.year_b, r.month_b, r.day_b))) begin
      res.status = ST_BAD;
    end else if (r.op == OP_DIFF) begin
      res.day_count = 26'(serial_day(r.year_a, r.month_a, r.day_a)
                          - serial_day(r.year_b, r.month_b, r.day_b));
    end else begin
      t = serial_day(r.year_a, r.month_a, r.day_a) + longint'(r.day_offset);
      y = floor_div(t * 400, 146097);
      while (jan_first(y + 1) <= t) y++;
      while (jan_first(y) > t) y--;
      if (y < -32768 || y > 32767) begin
        res.status = ST_RANGE;
      end else begin
        doy = t - jan_first(y);
        m = 1;
        while (m < 12 && doy >= days_before_month(y, m + 1)) m++;
        res.year_out  = 16'(y);
        res.month_out = 4'(m);
        res.day_out   = 5'(doy - days_before_month(y, m) + 1);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driving and checking.
  // ---------------------------------------------------------------------

  // Mostly short gaps, with the occasional long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one request: the payload is presented at a falling edge and held
  // until the transaction completes at a rising edge with in_stall low. The
  // task is entered and left at a falling edge; in_valid is dropped only when
  // a gap follows, so a back-to-back request keeps it high.
  task automatic send_date(date_req_t r, bit with_gap = 1'b1);
    int gap;
    gap = with_gap ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= r.op;
    in_year_a     <= r.year_a;
    in_month_a    <= r.month_a;
    in_day_a      <= r.day_a;
    in_day_offset <= r.day_offset;
    in_year_b     <= r.year_b;
    in_month_b    <= r.month_b;
    in_day_b      <= r.day_b;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(predict_date(r));
    @(negedge clk);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver stall pattern, updated at each falling edge.
  always @(negedge clk) begin
    if (!rst_n || !rx_stall_bursts) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // Every result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    date_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result year=%0d month=%0d day=%0d count=%0d st=%0d",
                 $time, out_year_out, out_month_out, out_day_out, out_day_count,
                 out_status);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_year_out !== want.year_out) begin
          $display("%0t: year_out expected %0d actual %0d", $time, want.year_out,
                   out_year_out);
          fail_count++;
        end
        if (out_month_out !== want.month_out) begin
          $display("%0t: month_out expected %0d actual %0d", $time, want.month_out,
                   out_month_out);
          fail_count++;
        end
        if (out_day_out !== want.day_out) begin
          $display("%0t: day_out expected %0d actual %0d", $time, want.day_out,
                   out_day_out);
          fail_count++;
        end
        if (out_day_count !== want.day_count) begin
          $display("%0t: day_count expected %0d actual %0d", $time, want.day_count,
                   out_day_count);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_status);
          fail_count++;
        end
      end
    end
  end

  function automatic date_req_t make_req(logic op, int ya, int ma, int da, int off,
                                         int yb, int mb, int db);
    date_req_t r;
    r.op = op;
    r.year_a = 16'(ya); r.month_a = 4'(ma); r.day_a = 5'(da);
    r.day_offset = 26'(off);
    r.year_b = 16'(yb); r.month_b = 4'(mb); r.day_b = 5'(db);
    return r;
  endfunction

  // A valid date, with years drawn from the whole range, near year zero, near its ends or on multiples of 400.
  function automatic void pick_date(output logic signed [15:0] y, output logic [3:0] m,
                                    output logic [4:0] d);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5)       y = 16'($urandom_range(0, 65535));
    else if (sel < 7)  y = 16'($urandom_range(0, 4000) - 2000);
    else if (sel == 7) y = 16'(32767 - $urandom_range(0, 3));
    else if (sel == 8) y = 16'(-32768 + $urandom_range(0, 3));
    else               y = 16'(400 * $urandom_range(0, 160) - 32000);
    m = 4'($urandom_range(1, 12));
    d = 5'($urandom_range(1, month_days(y, m)));
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Extremes of the fields, both operations and the named special cases.
  task automatic test_directed();
    send_date(make_req(OP_ADD, 2000, 2, 29, 0, 0, 0, 0));
    send_date(make_req(OP_ADD, 1900, 2, 29, 1, 0, 0, 0));      // not a leap year
    send_date(make_req(OP_ADD, 0, 2, 29, 365, 0, 0, 0));       // year zero is leap
    send_date(make_req(OP_ADD, 2024, 0, 5, 1, 0, 0, 0));       // month zero
    send_date(make_req(OP_ADD, 2024, 13, 5, 1, 0, 0, 0));
    send_date(make_req(OP_ADD, 2024, 15, 31, 1, -1, 15, 31));
    send_date(make_req(OP_ADD, 2024, 4, 31, 1, 0, 0, 0));      // day past month end
    send_date(make_req(OP_ADD, 2024, 4, 0, 1, 0, 0, 0));
    send_date(make_req(OP_ADD, 32767, 12, 31, 0, 0, 0, 0));
    send_date(make_req(OP_ADD, 32767, 12, 31, 1, 0, 0, 0));    // beyond the top year
    send_date(make_req(OP_ADD, -32768, 1, 1, 0, 0, 0, 0));
    send_date(make_req(OP_ADD, -32768, 1, 1, -1, 0, 0, 0));    // below the bottom year
    send_date(make_req(OP_ADD, 0, 1, 1, 33554431, 0, 0, 0));
    send_date(make_req(OP_ADD, 0, 1, 1, -33554432, 0, 0, 0));
    send_date(make_req(OP_ADD, -32768, 1, 1, 33554431, 0, 0, 0));
    send_date(make_req(OP_ADD, 32767, 12, 31, -33554432, 0, 0, 0));
    send_date(make_req(OP_DIFF, 32767, 12, 31, 0, -32768, 1, 1));
    send_date(make_req(OP_DIFF, -32768, 1, 1, 0, 32767, 12, 31));
    send_date(make_req(OP_DIFF, 2024, 3, 1, 0, 2024, 2, 29));
    send_date(make_req(OP_DIFF, 2024, 3, 1, 0, 2023, 2, 29));  // date B invalid
    send_date(make_req(OP_DIFF, 2023, 2, 29, 0, 2024, 3, 1));  // date A invalid
    send_date(make_req(OP_DIFF, 2024, 3, 1, 0, 2024, 0, 0));
    send_date(make_req(OP_DIFF, -1, 12, 31, -1, 0, 1, 1));
  endtask

  // Random requests, mostly valid dates, some with malformed fields.
  task automatic test_random(int count);
    date_req_t r;
    int        sel;
    for (int i = 0; i < count; i++) begin
      r.op = 1'($urandom_range(0, 1));
      pick_date(r.year_a, r.month_a, r.day_a);
      pick_date(r.year_b, r.month_b, r.day_b);
      sel = $urandom_range(0, 9);
      if (sel < 4)       r.day_offset = 26'($urandom_range(0, 2000) - 1000);
      else if (sel < 8)  r.day_offset = 26'($urandom());
      else               r.day_offset = 26'($urandom_range(0, 800000) - 400000);
      // A few requests carry raw field values, some of them invalid dates.
      if ($urandom_range(0, 99) < 10) begin
        r.month_a = 4'($urandom());
        r.day_a   = 5'($urandom());
      end
      if ($urandom_range(0, 99) < 10) begin
        r.month_b = 4'($urandom());
        r.day_b   = 5'($urandom());
      end
      send_date(r, rx_stall_bursts || (i % 200 < 150));
      // Hold off now and then until every outstanding result has come back.
      if (i % 300 == 299) drain();
    end
  endtask

  initial begin
    fail_count      = 0;
    rx_stall_bursts = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    out_stall       = 1'b0;
    in_op           = OP_ADD;
    in_year_a       = '0;
    in_month_a      = '0;
    in_day_a        = '0;
    in_day_offset   = '0;
    in_year_b       = '0;
    in_month_b      = '0;
    in_day_b        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(900);
    // Second half runs with the receiver stalling at random.
    drain();
    rx_stall_bursts = 1'b1;
    test_random(925);

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[gregorian_date_day_arithmetic_core] OK");
    end else begin
      $display("[gregorian_date_day_arithmetic_core] ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("[gregorian_date_day_arithmetic_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: gregorian_date_day_arithmetic_core.f
+incdir+rtl
rtl/gdda_pkg.sv
rtl/gdda_ctrl.sv
rtl/gdda_dp.sv
rtl/gregorian_date_day_arithmetic_core.sv
rtl/gdda_checker.sv
bench/tb_gregorian_date_day_arithmetic_core.sv
